// ===== hw/rtl/ssp_pkg.sv =====
// ssp_pkg: shared types, constants and table helper functions for the stereo panner
// no dependencies; used by the interfaces, the divider and the top level
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int SAMPLE_BITS_DEFAULT        = 24;
    localparam int GAIN_TABLE_DEPTH_DEFAULT   = 1024;
    localparam int GAIN_FRACTION_BITS_DEFAULT = 15;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PAN_LAW      = 2'd0,
        CFG_TARGET_PAN   = 2'd1,
        CFG_RAMP_SAMPLES = 2'd2
    } cfg_index_t;

    localparam int PAN_BITS    = 32;
    localparam int TARGET_BITS = 16;
    localparam int RAMP_BITS   = 16;

    localparam logic signed [TARGET_BITS-1:0] TARGET_MAX = 16'sd16384;
    localparam logic signed [TARGET_BITS-1:0] TARGET_MIN = -16'sd16384;
    localparam logic [RAMP_BITS-1:0]          RAMP_RESET = 16'd960;

    // 1.0 in Q2.30, as a 34-bit signed offset
    localparam logic signed [PAN_BITS+1:0] PAN_ONE_Q30 = 34'sd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;

    localparam int DIV_STEPS      = 32;
    localparam int DIV_COUNT_BITS = 5;

    typedef struct packed {
        logic                 start;
        logic [PAN_BITS-1:0]  dividend;
        logic [RAMP_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PAN_BITS-1:0] quotient;
    } div_rsp_t;

    // two multiply-by-x steps of the series, Q30
    function automatic longint unsigned sin_term(longint unsigned t, longint unsigned x);
        longint unsigned u;
        u = (t * x) >> 30;
        u = (u * x) >> 30;
        return u;
    endfunction

    // sin in Q30, series up to x^17 with truncating steps
    function automatic longint unsigned sin_q30(longint unsigned x);
        longint unsigned t;
        longint          s;
        t = x;
        s = longint'(x);
        t = sin_term(t, x) / 6;   s = s - longint'(t);
        t = sin_term(t, x) / 20;  s = s + longint'(t);
        t = sin_term(t, x) / 42;  s = s - longint'(t);
        t = sin_term(t, x) / 72;  s = s + longint'(t);
        t = sin_term(t, x) / 110; s = s - longint'(t);
        t = sin_term(t, x) / 156; s = s + longint'(t);
        t = sin_term(t, x) / 210; s = s - longint'(t);
        t = sin_term(t, x) / 272; s = s + longint'(t);
        if (s < 0)
        begin
            s = 0;
        end
        if (s > longint'(ONE_Q30))
        begin
            s = longint'(ONE_Q30);
        end
        return unsigned'(s);
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned w;
        r = 0;
        b = 64'd1 << 62;
        w = v;
        while (b > w)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (w >= r + b)
            begin
                w = w - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // round Q30 to the gain fraction width, capped at 1.0
    function automatic longint unsigned to_gain(longint unsigned q30, int frac_bits);
        longint unsigned g;
        g = (q30 + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        if (g > (64'd1 << frac_bits))
        begin
            g = 64'd1 << frac_bits;
        end
        return g;
    endfunction

endpackage

// ===== hw/rtl/ssp_in_if.sv =====
// ssp_in_if: valid/ready channel carrying one mono sample request
// depends on ssp_pkg for the default sample width
`timescale 1ns / 1ps

interface ssp_in_if #(
    parameter int SAMPLE_BITS = ssp_pkg::SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mono_sample;

    modport source (output valid, output mono_sample, input ready);
    modport sink (input valid, input mono_sample, output ready);
endinterface

// ===== hw/rtl/ssp_out_if.sv =====
// ssp_out_if: valid/ready channel carrying one left/right sample pair request
// depends on ssp_pkg for the default sample width
`timescale 1ns / 1ps

interface ssp_out_if #(
    parameter int SAMPLE_BITS = ssp_pkg::SAMPLE_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

// ===== hw/rtl/ssp_ram.sv =====
// ssp_ram: generic RAM, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps

module ssp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== hw/rtl/ssp_div.sv =====
// ssp_div: serial restoring divider, one quotient bit per cycle, for the ramp increment
// depends on ssp_pkg for the request and response structs
`timescale 1ns / 1ps

module ssp_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ssp_pkg::div_req_t req,
    output ssp_pkg::div_rsp_t rsp
);

    localparam int QW = ssp_pkg::PAN_BITS;
    localparam int DW = ssp_pkg::RAMP_BITS;

    logic                                busy_reg;
    logic                                done_reg;
    logic [ssp_pkg::DIV_COUNT_BITS-1:0]  count_reg;
    logic [DW-1:0]                       rem_reg;
    logic [QW-1:0]                       quo_reg;
    logic [DW-1:0]                       divisor_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[QW-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == ssp_pkg::DIV_COUNT_BITS'(ssp_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QW-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== hw/rtl/smoothed_stereo_panner.sv =====
// smoothed_stereo_panner: ramped constant-power (law 0) or sin^1.5 panner, mono in, stereo out
// depends on ssp_pkg, ssp_in_if, ssp_out_if, ssp_ram and ssp_div
// stages s1, s2, s3 and out, each registered; one sample per cycle while stereo.ready is high
// after reset the gain table ram is filled, GAIN_TABLE_DEPTH+1 entries, with input held off
// a changing target write with a nonzero ramp holds input off while the serial divider runs
// reset: pan centered, no ramp, law 0, target 0, ramp length 960
`timescale 1ns / 1ps

module smoothed_stereo_panner #(
    parameter int GAIN_TABLE_DEPTH   = ssp_pkg::GAIN_TABLE_DEPTH_DEFAULT,
    parameter int SAMPLE_BITS        = ssp_pkg::SAMPLE_BITS_DEFAULT,
    parameter int GAIN_FRACTION_BITS = ssp_pkg::GAIN_FRACTION_BITS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    ssp_in_if.sink                               mono,
    ssp_out_if.source                            stereo,
    input  logic                                 cfg_write_en,
    input  logic [ssp_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ssp_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int PB        = ssp_pkg::PAN_BITS;
    localparam int TB        = ssp_pkg::TARGET_BITS;
    localparam int RB        = ssp_pkg::RAMP_BITS;
    localparam int GW        = GAIN_FRACTION_BITS + 1;
    localparam int ENTRY_W   = 2 * GW;
    localparam int ROM_DEPTH = GAIN_TABLE_DEPTH + 1;
    localparam int AW        = $clog2(ROM_DEPTH);
    localparam int KPW       = PB + AW + 1;
    localparam int PRODW     = SAMPLE_BITS + GW + 1;
    localparam int QW        = PRODW + 1 - GAIN_FRACTION_BITS;

    typedef logic [ENTRY_W-1:0] gain_rom_t [ROM_DEPTH];

    // entry k holds {power 1.5 gain, sin gain}
    function automatic gain_rom_t build_gain_rom();
        gain_rom_t       rom;
        longint unsigned x;
        longint unsigned s;
        longint unsigned r;
        longint unsigned p;
        for (int k = 0; k < ROM_DEPTH; k++)
        begin
            x = (longint'(k) * ssp_pkg::HALF_PI_Q30 + GAIN_TABLE_DEPTH / 2)
                / GAIN_TABLE_DEPTH;
            s = ssp_pkg::sin_q30(x);
            r = ssp_pkg::isqrt64(s << 30);
            p = (s * r + (64'd1 << 29)) >> 30;
            rom[k] = {GW'(ssp_pkg::to_gain(p, GAIN_FRACTION_BITS)),
                      GW'(ssp_pkg::to_gain(s, GAIN_FRACTION_BITS))};
        end
        return rom;
    endfunction

    localparam gain_rom_t GAIN_ROM = build_gain_rom();

    // configuration and pan state
    logic                 law_reg;
    logic signed [TB-1:0] target_reg;
    logic [RB-1:0]        ramp_len_reg;
    logic signed [PB-1:0] pan_reg;
    logic signed [PB-1:0] pan_next;
    logic signed [PB-1:0] inc_reg;
    logic [RB-1:0]        remain_reg;
    logic [RB-1:0]        remain_next;
    logic                 inc_pending_reg;
    logic                 inc_neg_reg;

    logic                 fill_active_reg;
    logic [AW-1:0]        fill_addr_reg;

    // pipeline
    logic                          s1_valid_reg;
    logic signed [PB-1:0]          s1_pan_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic                          s2_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s2_x_reg;
    logic                          s3_valid_reg;
    logic signed [PRODW-1:0]       s3_left_reg;
    logic signed [PRODW-1:0]       s3_right_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;

    logic en_out;
    logic en3;
    logic en2;
    logic en1;
    logic accept;

    ssp_pkg::div_req_t div_req;
    ssp_pkg::div_rsp_t div_rsp;

    // configuration decode
    logic signed [TB-1:0]   cfg_target;
    logic signed [PB-1:0]   cfg_target_q30;
    logic signed [PB:0]     cfg_diff;
    logic [PB:0]            cfg_mag;
    logic                   target_write;
    logic                   target_change;

    always_comb
    begin
        cfg_target = $signed(cfg_data[TB-1:0]);
        if (cfg_target > ssp_pkg::TARGET_MAX)
        begin
            cfg_target = ssp_pkg::TARGET_MAX;
        end
        else if (cfg_target < ssp_pkg::TARGET_MIN)
        begin
            cfg_target = ssp_pkg::TARGET_MIN;
        end
        cfg_target_q30 = {cfg_target, 16'b0};
        cfg_diff       = {cfg_target_q30[PB-1], cfg_target_q30} - {pan_reg[PB-1], pan_reg};
        cfg_mag        = cfg_diff[PB] ? (PB+1)'(-cfg_diff) : cfg_diff;
        target_write   = cfg_write_en && (cfg_index == ssp_pkg::CFG_TARGET_PAN);
        target_change  = target_write && (cfg_target != target_reg);
    end

    assign div_req.start    = target_change && (ramp_len_reg != '0);
    assign div_req.dividend = cfg_mag[PB-1:0];
    assign div_req.divisor  = ramp_len_reg;

    ssp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // handshake chain
    assign en_out      = !out_valid_reg || stereo.ready;
    assign en3         = !s3_valid_reg || en_out;
    assign en2         = !s2_valid_reg || en3;
    assign en1         = !s1_valid_reg || en2;
    assign mono.ready  = en1 && !fill_active_reg && !inc_pending_reg;
    assign accept      = mono.valid && mono.ready;

    // pan step for one sample
    always_comb
    begin
        pan_next    = pan_reg;
        remain_next = remain_reg;
        if (remain_reg != '0)
        begin
            remain_next = remain_reg - 1'b1;
            if (remain_reg == RB'(1))
            begin
                pan_next = {target_reg, 16'b0};
            end
            else
            begin
                pan_next = pan_reg + inc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg         <= 1'b0;
            target_reg      <= '0;
            ramp_len_reg    <= ssp_pkg::RAMP_RESET;
            pan_reg         <= '0;
            inc_reg         <= '0;
            remain_reg      <= '0;
            inc_pending_reg <= 1'b0;
            inc_neg_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pan_reg    <= pan_next;
                remain_reg <= remain_next;
            end
            if (inc_pending_reg && div_rsp.done)
            begin
                inc_reg         <= inc_neg_reg ? -div_rsp.quotient : div_rsp.quotient;
                inc_pending_reg <= 1'b0;
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    ssp_pkg::CFG_PAN_LAW:
                    begin
                        law_reg <= cfg_data[0];
                    end
                    ssp_pkg::CFG_TARGET_PAN:
                    begin
                        if (target_change)
                        begin
                            target_reg <= cfg_target;
                            if (ramp_len_reg == '0)
                            begin
                                pan_reg         <= cfg_target_q30;
                                inc_reg         <= '0;
                                remain_reg      <= '0;
                                inc_pending_reg <= 1'b0;
                            end
                            else
                            begin
                                remain_reg      <= ramp_len_reg;
                                inc_neg_reg     <= cfg_diff[PB];
                                inc_pending_reg <= 1'b1;
                            end
                        end
                    end
                    ssp_pkg::CFG_RAMP_SAMPLES:
                    begin
                        ramp_len_reg    <= cfg_data[RB-1:0];
                        pan_reg         <= {target_reg, 16'b0};
                        inc_reg         <= '0;
                        remain_reg      <= '0;
                        inc_pending_reg <= 1'b0;
                    end
                    default:
                    begin
                        law_reg <= law_reg;
                    end
                endcase
            end
        end
    end

    // gain table fill after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b1;
            fill_addr_reg   <= '0;
        end
        else if (fill_active_reg)
        begin
            fill_addr_reg <= fill_addr_reg + 1'b1;
            if (fill_addr_reg == AW'(GAIN_TABLE_DEPTH))
            begin
                fill_active_reg <= 1'b0;
            end
        end
    end

    // table position from the registered pan
    logic [PB:0]     pos_s;
    logic [PB-1:0]   pos;
    logic [KPW-1:0]  k_sum;
    logic [AW+1:0]   k_raw;
    logic [AW-1:0]   k_right;
    logic [AW-1:0]   k_left;

    always_comb
    begin
        pos_s = PB'(0) + ({s1_pan_reg[PB-1], s1_pan_reg} + (PB+1)'(ssp_pkg::PAN_ONE_Q30));
        pos   = pos_s[PB] ? '0 : pos_s[PB-1:0];
        k_sum = KPW'(pos) * KPW'(GAIN_TABLE_DEPTH) + (KPW'(1) << 30);
        k_raw = k_sum[KPW-1:31];
        if (k_raw > (AW+2)'(GAIN_TABLE_DEPTH))
        begin
            k_right = AW'(GAIN_TABLE_DEPTH);
        end
        else
        begin
            k_right = k_raw[AW-1:0];
        end
        k_left = AW'(GAIN_TABLE_DEPTH) - k_right;
    end

    logic [ENTRY_W-1:0] gain_r_entry;
    logic [ENTRY_W-1:0] gain_l_entry;

    ssp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROM_DEPTH)
    ) u_gain_ram (
        .clk     (clk),
        .we      (fill_active_reg),
        .waddr   (fill_addr_reg),
        .wdata   (GAIN_ROM[fill_addr_reg]),
        .re      (en2),
        .raddr_a (k_right),
        .raddr_b (k_left),
        .rdata_a (gain_r_entry),
        .rdata_b (gain_l_entry)
    );

    // gain select and products
    logic [GW-1:0] gain_l;
    logic [GW-1:0] gain_r;

    assign gain_l = law_reg ? gain_l_entry[ENTRY_W-1:GW] : gain_l_entry[GW-1:0];
    assign gain_r = law_reg ? gain_r_entry[ENTRY_W-1:GW] : gain_r_entry[GW-1:0];

    // round half up, then saturate
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(logic signed [PRODW-1:0] p);
        logic signed [PRODW:0]  v;
        logic signed [QW-1:0]   q;
        logic signed [SAMPLE_BITS-1:0] r;
        v = {p[PRODW-1], p} + ((PRODW+1)'(1) << (GAIN_FRACTION_BITS - 1));
        q = QW'(v >>> GAIN_FRACTION_BITS);
        if (q[QW-1:SAMPLE_BITS-1] == '0 || q[QW-1:SAMPLE_BITS-1] == '1)
        begin
            r = q[SAMPLE_BITS-1:0];
        end
        else if (q[QW-1])
        begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= accept;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pan_reg <= pan_next;
            s1_x_reg   <= mono.mono_sample;
        end
        if (en2)
        begin
            s2_x_reg <= s1_x_reg;
        end
        if (en3)
        begin
            s3_left_reg  <= PRODW'(s2_x_reg) * PRODW'($signed({1'b0, gain_l}));
            s3_right_reg <= PRODW'(s2_x_reg) * PRODW'($signed({1'b0, gain_r}));
        end
        if (en_out)
        begin
            out_left_reg  <= round_sat(s3_left_reg);
            out_right_reg <= round_sat(s3_right_reg);
        end
    end

    assign stereo.valid        = out_valid_reg;
    assign stereo.left_sample  = out_left_reg;
    assign stereo.right_sample = out_right_reg;

endmodule

// ===== tb/smoothed_stereo_panner_tb.sv =====
// smoothed_stereo_panner_tb: checks the ramped panner against a gain-table and pan-ramp predictor
// drives directed then random mono requests through valid/ready with random idling on both sides
// depends on ssp_pkg, ssp_in_if, ssp_out_if and smoothed_stereo_panner
`timescale 1ns / 1ps

module smoothed_stereo_panner_tb;
    import ssp_pkg::*;

    localparam int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT;
    localparam int TABLE_DEPTH    = GAIN_TABLE_DEPTH_DEFAULT;
    localparam int FRAC_BITS      = GAIN_FRACTION_BITS_DEFAULT;
    localparam int PIPE_LATENCY   = 4;
    localparam int RANDOM_SAMPLES = 1880;
    localparam int QUIET_PHASE    = 5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef longint unsigned u64_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef struct {
        sample_t left_sample;
        sample_t right_sample;
    } stereo_pair_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    class pan_scoreboard;
        int unsigned                   sin_gain[TABLE_DEPTH+1];
        int unsigned                   pow_gain[TABLE_DEPTH+1];
        bit                            law;
        logic signed [TARGET_BITS-1:0] target;
        logic [RAMP_BITS-1:0]          ramp_len;
        logic signed [PAN_BITS-1:0]    pan;
        logic signed [PAN_BITS-1:0]    pan_step;
        logic [RAMP_BITS-1:0]          ramp_left;
        stereo_pair_t                  expected_pairs[$];
        int                            mismatches;
        int                            pairs_checked;

        function new();
            u64_t angle;
            u64_t s;
            u64_t p;
            int   k;
            for (k = 0; k <= TABLE_DEPTH; k++)
            begin
                angle = (longint'(k) * HALF_PI_Q30 + TABLE_DEPTH / 2) / TABLE_DEPTH;
                s = series_sin(angle);
                p = (s * root_floor(s << 30) + (u64_t'(1) << 29)) >> 30;
                sin_gain[k] = round_gain(s);
                pow_gain[k] = round_gain(p);
            end
            law           = 1'b0;
            target        = '0;
            ramp_len      = RAMP_RESET;
            pan           = '0;
            pan_step      = '0;
            ramp_left     = '0;
            mismatches    = 0;
            pairs_checked = 0;
        endfunction

        // taylor series to x^17 in q30, truncating each step
        function u64_t series_sin(u64_t x);
            u64_t   term;
            longint acc;
            int     n;
            term = x;
            acc  = longint'(x);
            for (n = 3; n <= 17; n += 2)
            begin
                term = ((((term * x) >> 30) * x) >> 30) / u64_t'((n - 1) * n);
                if (((n - 1) / 2) % 2 == 1)
                    acc -= longint'(term);
                else
                    acc += longint'(term);
            end
            if (acc < 0)
                acc = 0;
            if (acc > longint'(ONE_Q30))
                acc = longint'(ONE_Q30);
            return u64_t'(acc);
        endfunction

        function u64_t root_floor(u64_t v);
            u64_t r;
            u64_t trial;
            int   b;
            r = 0;
            for (b = 31; b >= 0; b--)
            begin
                trial = r | (u64_t'(1) << b);
                if (trial * trial <= v)
                    r = trial;
            end
            return r;
        endfunction

        function int unsigned round_gain(u64_t q30);
            u64_t g;
            g = (q30 + (u64_t'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
            if (g > (u64_t'(1) << FRAC_BITS))
                g = u64_t'(1) << FRAC_BITS;
            return 32'(g);
        endfunction

        function longint target_q30();
            return longint'(target) * 65536;
        endfunction

        function sample_t apply_gain(sample_t x, int unsigned g);
            longint v;
            v = (longint'(x) * longint'(g) + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            if (v > longint'(SAMPLE_MAX))
                v = longint'(SAMPLE_MAX);
            if (v < longint'(SAMPLE_MIN))
                v = longint'(SAMPLE_MIN);
            return sample_t'(v);
        endfunction

        function void note_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            logic signed [TARGET_BITS-1:0] t;
            longint                        gap;
            u64_t                          mag;
            case (idx)
                CFG_PAN_LAW:
                    law = value[0];
                CFG_TARGET_PAN:
                begin
                    t = value;
                    if (t > TARGET_MAX)
                        t = TARGET_MAX;
                    if (t < TARGET_MIN)
                        t = TARGET_MIN;
                    if (t != target)
                    begin
                        target = t;
                        if (ramp_len == 0)
                        begin
                            pan       = PAN_BITS'(target_q30());
                            pan_step  = '0;
                            ramp_left = '0;
                        end
                        else
                        begin
                            gap       = target_q30() - longint'(pan);
                            mag       = u64_t'(gap < 0 ? -gap : gap) / ramp_len;
                            pan_step  = PAN_BITS'((gap < 0) ? -longint'(mag) : longint'(mag));
                            ramp_left = ramp_len;
                        end
                    end
                end
                CFG_RAMP_SAMPLES:
                begin
                    ramp_len  = value;
                    pan       = PAN_BITS'(target_q30());
                    pan_step  = '0;
                    ramp_left = '0;
                end
                default:
                    ;
            endcase
        endfunction

        function void note_sample(sample_t x);
            longint       pos;
            u64_t         k;
            int unsigned  gl;
            int unsigned  gr;
            stereo_pair_t pair;
            if (ramp_left != 0)
            begin
                ramp_left--;
                if (ramp_left == 0)
                    pan = PAN_BITS'(target_q30());
                else
                    pan = pan + pan_step;
            end
            pos = longint'(pan) + longint'(PAN_ONE_Q30);
            if (pos < 0)
                pos = 0;
            k = (u64_t'(pos) * TABLE_DEPTH + (u64_t'(1) << 30)) >> 31;
            if (k > TABLE_DEPTH)
                k = TABLE_DEPTH;
            gl = law ? pow_gain[TABLE_DEPTH - k] : sin_gain[TABLE_DEPTH - k];
            gr = law ? pow_gain[k] : sin_gain[k];
            pair.left_sample  = apply_gain(x, gl);
            pair.right_sample = apply_gain(x, gr);
            expected_pairs.push_back(pair);
        endfunction

        function void compare_field(string name, sample_t want, sample_t got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t %s expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_pair(sample_t l, sample_t r);
            stereo_pair_t want;
            pairs_checked++;
            if (expected_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result left %0d right %0d", $time, l, r);
                return;
            end
            want = expected_pairs.pop_front();
            compare_field("left_sample", want.left_sample, l);
            compare_field("right_sample", want.right_sample, r);
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    bit                        gaps_on;
    int                        requests_sent;
    int                        phases_run;
    int                        writes_done;
    pan_scoreboard             book;

    ssp_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) mono ();
    ssp_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) stereo ();

    smoothed_stereo_panner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .mono         (mono),
        .stereo       (stereo),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: check accepted pairs, stall at random
    initial
    begin
        stereo.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stereo.valid === 1'b1 && stereo.ready === 1'b1)
                book.check_pair(stereo.left_sample, stereo.right_sample);
            stereo.ready <= !(gaps_on && $urandom_range(99) < 26);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        book.note_write(idx, value);
        writes_done++;
    endtask

    task automatic send_sample(input sample_t x);
        while (gaps_on && $urandom_range(99) < 26)
        begin
            mono.valid <= 1'b0;
            @(posedge clk);
        end
        mono.valid       <= 1'b1;
        mono.mono_sample <= x;
        @(posedge clk);
        while (mono.ready !== 1'b1)
            @(posedge clk);
        book.note_sample(x);
        requests_sent++;
    endtask

    task automatic drain_pipeline();
        mono.valid <= 1'b0;
        while (book.expected_pairs.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(19))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return sample_t'(-1);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic reconfigure();
        logic [RAMP_BITS-1:0]   ramp_value;
        logic [TARGET_BITS-1:0] target_value;
        case ($urandom_range(5))
            0: ramp_value = '0;
            1: ramp_value = 16'd1;
            2: ramp_value = '1;
            3, 4: ramp_value = 16'($urandom_range(64, 2));
            default: ramp_value = 16'($urandom_range(3000, 65));
        endcase
        case ($urandom_range(5))
            0: target_value = TARGET_MAX;
            1: target_value = TARGET_MIN;
            2: target_value = 16'($urandom);
            3: target_value = book.target;
            default: target_value = 16'($urandom_range(32768, 0) - 16384);
        endcase
        if ($urandom_range(99) < 50)
            write_reg(CFG_PAN_LAW, 16'($urandom));
        if ($urandom_range(99) < 15)
            write_reg(CFG_UNUSED, 16'($urandom));
        if ($urandom_range(99) < 40)
            write_reg(CFG_RAMP_SAMPLES, ramp_value);
        write_reg(CFG_TARGET_PAN, target_value);
        // ramp length after the target snaps straight to it
        if ($urandom_range(99) < 10)
            write_reg(CFG_RAMP_SAMPLES, ramp_value);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        int n;
        int count;
        int sent_random;
        book             = new();
        gaps_on          = 1'b1;
        rst_n            = 1'b0;
        cfg_write_en     = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        mono.valid       = 1'b0;
        mono.mono_sample = '0;
        requests_sent    = 0;
        phases_run       = 0;
        writes_done      = 0;
        sent_random      = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // centered, no ramp, law bit clear under set upper bits
        write_reg(CFG_RAMP_SAMPLES, 16'd0);
        write_reg(CFG_PAN_LAW, 16'hFFFE);
        cfg_write_en <= 1'b0;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(0));
        send_sample(sample_t'(-1));
        send_sample(sample_t'(1));

        // out of range target clamps to full right, jumps with zero ramp
        drain_pipeline();
        write_reg(CFG_TARGET_PAN, 16'h7FFF);
        cfg_write_en <= 1'b0;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(12345));

        // clamped full left under the power law
        drain_pipeline();
        write_reg(CFG_TARGET_PAN, 16'h8000);
        write_reg(CFG_PAN_LAW, 16'h0001);
        cfg_write_en <= 1'b0;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(sample_t'(-77777));

        // unused index is ignored, back to center
        drain_pipeline();
        write_reg(CFG_UNUSED, 16'hA5A5);
        write_reg(CFG_TARGET_PAN, 16'h0000);
        cfg_write_en <= 1'b0;
        send_sample(SAMPLE_MAX);

        // short ramp toward half right
        drain_pipeline();
        write_reg(CFG_RAMP_SAMPLES, 16'd6);
        write_reg(CFG_TARGET_PAN, 16'h2000);
        cfg_write_en <= 1'b0;
        repeat (3) send_sample(pick_sample());

        // same target again keeps the ramp, law change mid ramp
        drain_pipeline();
        write_reg(CFG_TARGET_PAN, 16'h2000);
        write_reg(CFG_PAN_LAW, 16'h0000);
        cfg_write_en <= 1'b0;
        repeat (4) send_sample(SAMPLE_MAX);

        // new target, then longest ramp length snaps to it
        drain_pipeline();
        write_reg(CFG_TARGET_PAN, 16'hE000);
        cfg_write_en <= 1'b0;
        repeat (2) send_sample(SAMPLE_MIN);
        drain_pipeline();
        write_reg(CFG_RAMP_SAMPLES, 16'hFFFF);
        cfg_write_en <= 1'b0;
        repeat (2) send_sample(SAMPLE_MAX);

        while (sent_random < RANDOM_SAMPLES)
        begin
            drain_pipeline();
            reconfigure();
            gaps_on = (phases_run != QUIET_PHASE);
            count   = (phases_run == QUIET_PHASE) ? 300 : $urandom_range(160, 40);
            for (n = 0; n < count; n++)
                send_sample(pick_sample());
            sent_random += count;
            phases_run++;
        end
        gaps_on = 1'b1;
        drain_pipeline();

        $display("checked %0d stereo pairs from %0d mono requests", book.pairs_checked,
                 requests_sent);
        $display("%0d register writes over %0d random settings, both laws, ramps 0 to 65535",
                 writes_done, phases_run);
        if (book.mismatches == 0 && book.expected_pairs.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_in_if.sv
hw/rtl/ssp_out_if.sv
hw/rtl/ssp_ram.sv
hw/rtl/ssp_div.sv
hw/rtl/smoothed_stereo_panner.sv
tb/smoothed_stereo_panner_tb.sv
